// ===== hw/rtl/rtcc_pkg.sv =====
// shared types, codes and calendar helpers for the calendar clock
`timescale 1ns / 1ps
`default_nettype none

package rtcc_pkg;

    // action codes; the spare code behaves as a read
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_SET  = 2'd1;

    localparam int unsigned SEC_PER_MIN  = 60;
    localparam int unsigned MIN_PER_HOUR = 60;
    localparam int unsigned HOUR_PER_DAY = 24;
    localparam int unsigned YEAR_LOW     = 2000;
    localparam int unsigned YEAR_HIGH    = 3000;
    localparam int unsigned MONTH_LAST   = 12;
    localparam int unsigned DAY_LAST     = 31;

    localparam logic [0:0] REG_TICKS_PER_SECOND = 1'b0;
    localparam logic [19:0] TPS_RESET = 20'd1000;

    // reciprocal of 100 scaled by 2^21, exact for any 14-bit year
    localparam int unsigned RECIP_SHIFT = 21;
    localparam logic [14:0] RECIP_100   = 15'd20972;

    typedef struct packed {
        logic [1:0]  action;
        logic [13:0] set_year;
        logic [6:0]  set_month;
        logic [6:0]  set_day;
        logic [6:0]  set_hour;
        logic [6:0]  set_minute;
        logic [6:0]  set_second;
    } cmd_t;

    typedef struct packed {
        logic        status;
        logic        second_done;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } rsp_t;

    // gregorian leap test; century check via reciprocal multiply
    function automatic logic is_leap(input logic [13:0] y);
        logic [28:0] prod;
        logic        century;
        prod    = 29'(y) * 29'(RECIP_100);
        century = (prod[RECIP_SHIFT-1:0] < 21'(RECIP_100));
        is_leap = ((y[1:0] == 2'd0) && !century)
                || (century && (prod[RECIP_SHIFT+1:RECIP_SHIFT] == 2'd0));
    endfunction

    // month length in days; month 0 counts as a long month
    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        month_len = len;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rtcc_cfg.sv =====
// apb register block holding the tick rate
`timescale 1ns / 1ps
`default_nettype none

module rtcc_cfg
    import rtcc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [19:0] ticks_per_second
);

    logic [19:0] tps_reg;
    logic [19:0] tps_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == REG_TICKS_PER_SECOND);

    always_comb
    begin
        tps_next = tps_reg;
        if (wr_en)
        begin
            tps_next = pwdata[19:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg <= TPS_RESET;
        end
        else
        begin
            tps_reg <= tps_next;
        end
    end

    assign prdata = (paddr == REG_TICKS_PER_SECOND) ? {12'd0, tps_reg} : 32'd0;
    assign ticks_per_second = tps_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rtcc_in_stage.sv =====
// input register stage for command words
`timescale 1ns / 1ps
`default_nettype none

module rtcc_in_stage
    import rtcc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_stall,
    input  wire cmd_t cmd_word,
    input  wire logic advance,
    output logic      item_valid,
    output cmd_t      item
);

    logic vld_reg;
    logic vld_next;
    cmd_t item_reg;
    logic accept;

    assign cmd_stall = vld_reg && !advance;
    assign accept    = cmd_valid && !cmd_stall;

    always_comb
    begin
        vld_next = vld_reg;
        if (accept)
        begin
            vld_next = 1'b1;
        end
        else if (advance)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= cmd_word;
        end
    end

    assign item_valid = vld_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rtcc_core.sv =====
// clock state, tick divider, rollover and set logic with result register
`timescale 1ns / 1ps
`default_nettype none

module rtcc_core
    import rtcc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [19:0] ticks_per_second,
    input  wire logic        item_valid,
    input  wire cmd_t        item,
    output logic             advance,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output rsp_t             rsp_word
);

    logic [19:0] div_reg,   div_next;
    logic [13:0] year_reg,  year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg,   day_next;
    logic [4:0]  hour_reg,  hour_next;
    logic [5:0]  min_reg,   min_next;
    logic [5:0]  sec_reg,   sec_next;
    logic        rsp_vld_reg, rsp_vld_next;
    rsp_t        rsp_reg,   rsp_next;

    logic [19:0] rate;
    logic [20:0] div_inc;
    logic        done;
    logic [4:0]  mlen;
    logic [5:0]  day_inc;
    logic        set_ok;
    logic        do_tick;
    logic        do_set;

    assign advance = !rsp_vld_reg || !rsp_stall;
    assign do_tick = advance && item_valid && (item.action == ACT_TICK);
    assign do_set  = advance && item_valid && (item.action == ACT_SET);

    // divider: a zero rate behaves as one tick per second
    assign rate    = (ticks_per_second == 20'd0) ? 20'd1 : ticks_per_second;
    assign div_inc = {1'b0, div_reg} + 21'd1;
    assign done    = (div_inc >= {1'b0, rate});

    assign mlen    = month_len(is_leap(year_reg), month_reg);
    assign day_inc = {1'b0, day_reg} + 6'd1;

    assign set_ok = (item.set_year >= 14'(YEAR_LOW)) && (item.set_year <= 14'(YEAR_HIGH))
                 && (item.set_month >= 7'd1) && (item.set_month <= 7'(MONTH_LAST))
                 && (item.set_day >= 7'd1) && (item.set_day <= 7'(DAY_LAST))
                 && (item.set_hour < 7'(HOUR_PER_DAY))
                 && (item.set_minute < 7'(MIN_PER_HOUR))
                 && (item.set_second < 7'(SEC_PER_MIN));

    always_comb
    begin
        div_next   = div_reg;
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        hour_next  = hour_reg;
        min_next   = min_reg;
        sec_next   = sec_reg;
        if (do_tick)
        begin
            div_next = done ? 20'(div_inc - {1'b0, rate}) : div_inc[19:0];
            if (done)
            begin
                // second, minute, hour, day, month, year ripple
                if (sec_reg < 6'(SEC_PER_MIN - 1))
                begin
                    sec_next = sec_reg + 6'd1;
                end
                else
                begin
                    sec_next = 6'd0;
                    if (min_reg < 6'(MIN_PER_HOUR - 1))
                    begin
                        min_next = min_reg + 6'd1;
                    end
                    else
                    begin
                        min_next = 6'd0;
                        if (hour_reg < 5'(HOUR_PER_DAY - 1))
                        begin
                            hour_next = hour_reg + 5'd1;
                        end
                        else
                        begin
                            hour_next = 5'd0;
                            if (day_inc <= {1'b0, mlen})
                            begin
                                day_next = day_inc[4:0];
                            end
                            else
                            begin
                                day_next = 5'd1;
                                if (month_reg >= 4'(MONTH_LAST))
                                begin
                                    month_next = 4'd1;
                                    year_next  = year_reg + 14'd1;
                                end
                                else
                                begin
                                    month_next = month_reg + 4'd1;
                                end
                            end
                        end
                    end
                end
            end
        end
        else if (do_set && set_ok)
        begin
            year_next  = item.set_year;
            month_next = item.set_month[3:0];
            day_next   = item.set_day[4:0];
            hour_next  = item.set_hour[4:0];
            min_next   = item.set_minute[5:0];
            sec_next   = item.set_second[5:0];
        end
    end

    always_comb
    begin
        rsp_vld_next = rsp_vld_reg;
        rsp_next     = rsp_reg;
        if (advance)
        begin
            rsp_vld_next         = item_valid;
            rsp_next.status      = do_set && !set_ok;
            rsp_next.second_done = do_tick && done;
            rsp_next.year        = year_next;
            rsp_next.month       = month_next;
            rsp_next.day         = day_next;
            rsp_next.hour        = hour_next;
            rsp_next.minute      = min_next;
            rsp_next.second      = sec_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg     <= 20'd0;
            year_reg    <= 14'd0;
            month_reg   <= 4'd0;
            day_reg     <= 5'd0;
            hour_reg    <= 5'd0;
            min_reg     <= 6'd0;
            sec_reg     <= 6'd0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            div_reg     <= div_next;
            year_reg    <= year_next;
            month_reg   <= month_next;
            day_reg     <= day_next;
            hour_reg    <= hour_next;
            min_reg     <= min_next;
            sec_reg     <= sec_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp_word  = rsp_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/calendar_clock_with_tick_divider_top.sv =====
// top level of the calendar clock with tick divider
`timescale 1ns / 1ps
`default_nettype none

// usage:
//   cmd channel (cmd_valid / cmd_stall / cmd_word) carries one word per action:
//   tick advances the divider, set loads a checked date and time, read only
//   reports. every cmd word yields exactly one rsp word on the rsp channel
//   (rsp_valid / rsp_stall / rsp_word) with status, second_done and the time.
//   a word is taken at a rising edge with valid high and stall low.
//   a word accepted into the input register passes on to the result register,
//   which drives rsp_word. throughput: one word per cycle while the receiver
//   does not stall; the calendar update is a single pass of logic between the
//   input register and the result register. when the receiver stalls, the
//   result register holds its word, and the input register takes one more
//   word only if it is empty; cmd_stall goes high once it is full.
//   reset clears the clock to zero (month 0, counted as a 31-day month) and
//   sets ticks_per_second to 1000. apb register 0 holds ticks_per_second; the
//   user must write it only while the block is idle; the block does not check.
module calendar_clock_with_tick_divider_top
    import rtcc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // apb configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // command words
    input  wire logic        cmd_valid,
    output logic             cmd_stall,
    input  wire cmd_t        cmd_word,
    // result words
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output rsp_t             rsp_word
);

    logic [19:0] ticks_per_second;
    logic        advance;     // result register can take a word this cycle
    logic        item_valid;
    cmd_t        item;

    // tick rate register
    rtcc_cfg u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .ticks_per_second (ticks_per_second)
    );

    // input register; stalls only when full and the result side is blocked
    rtcc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_word   (cmd_word),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // calendar state, divider and result register
    rtcc_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .ticks_per_second (ticks_per_second),
        .item_valid       (item_valid),
        .item             (item),
        .advance          (advance),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .rsp_word         (rsp_word)
    );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the calendar clock with tick divider
`timescale 1ns / 1ps

module testbench;
    import rtcc_pkg::*;

    // action codes that the package leaves unnamed
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    // ticks_per_second is register 0, byte address 0
    localparam logic [0:0] RATE_ADDR = 1'b0;
    localparam logic [19:0] RATE_AT_RESET = 20'd1000;

    // calendar limits, kept apart from the design's own copies
    localparam int LOWEST_YEAR   = 2000;
    localparam int HIGHEST_YEAR  = 3000;
    localparam int LAST_MONTH    = 12;
    localparam int LAST_DAY      = 31;
    localparam int HOURS_PER_DAY = 24;
    localparam int MINS_PER_HOUR = 60;
    localparam int SECS_PER_MIN  = 60;

    localparam int IDLE_PERCENT   = 6;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 10;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [0:0]  paddr = RATE_ADDR;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    cmd_t        cmd_word = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_t        rsp_word;

    calendar_clock_with_tick_divider_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    // 10 ns clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predicted clock state, mirrors what the block should hold
    // ------------------------------------------------------------------
    logic [19:0] model_rate    = RATE_AT_RESET;
    logic [19:0] model_divider = '0;
    logic [13:0] cal_year      = '0;
    logic [3:0]  cal_month     = '0;
    logic [4:0]  cal_day       = '0;
    logic [4:0]  cal_hour      = '0;
    logic [5:0]  cal_minute    = '0;
    logic [5:0]  cal_second    = '0;

    // expected result words, oldest first
    rsp_t expected_times[$];

    int  error_count = 0;
    bit  quiet = 1'b0;      // no random idling on either side while set
    int  hold_cycles = 0;   // long receiver hold-off, counted down by the receiver

    function automatic bit leap_year(input logic [13:0] y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // month 0 (before any set) counts as a long month
    function automatic int days_in_month(input logic [13:0] y, input logic [3:0] m);
        case (m)
            4'd2:                      return leap_year(y) ? 29 : 28;
            4'd4, 4'd6, 4'd9, 4'd11:   return 30;
            default:                   return 31;
        endcase
    endfunction

    // one completed second ripples through the calendar
    function automatic void bump_second();
        if (int'(cal_second) + 1 < SECS_PER_MIN)
        begin
            cal_second++;
            return;
        end
        cal_second = '0;
        if (int'(cal_minute) + 1 < MINS_PER_HOUR)
        begin
            cal_minute++;
            return;
        end
        cal_minute = '0;
        if (int'(cal_hour) + 1 < HOURS_PER_DAY)
        begin
            cal_hour++;
            return;
        end
        cal_hour = '0;
        // a day loaded past the month's end also wraps here
        if (int'(cal_day) + 1 <= days_in_month(cal_year, cal_month))
        begin
            cal_day++;
            return;
        end
        cal_day = 5'd1;
        if (int'(cal_month) >= LAST_MONTH)
        begin
            cal_month = 4'd1;
            cal_year  = cal_year + 14'd1;   // wraps at 14 bits
        end
        else
        begin
            cal_month++;
        end
    endfunction

    // applies one command word to the predicted clock, returns its result word
    function automatic rsp_t calendar_step(input cmd_t c);
        rsp_t        r;
        logic [20:0] nxt;
        logic [19:0] eff_rate;
        bit          ok;
        r = '0;
        if (c.action == ACT_TICK)
        begin
            // a rate of zero behaves as one tick per second
            eff_rate = (model_rate == '0) ? 20'd1 : model_rate;
            nxt = {1'b0, model_divider} + 21'd1;
            // divider may sit above a freshly lowered rate: one second per tick at most
            if (nxt >= {1'b0, eff_rate})
            begin
                nxt = nxt - {1'b0, eff_rate};
                r.second_done = 1'b1;
            end
            model_divider = nxt[19:0];
            if (r.second_done)
                bump_second();
        end
        else if (c.action == ACT_SET)
        begin
            ok = (c.set_year >= LOWEST_YEAR) && (c.set_year <= HIGHEST_YEAR)
              && (c.set_month >= 1) && (c.set_month <= LAST_MONTH)
              && (c.set_day >= 1) && (c.set_day <= LAST_DAY)
              && (c.set_hour < HOURS_PER_DAY)
              && (c.set_minute < MINS_PER_HOUR)
              && (c.set_second < SECS_PER_MIN);
            if (ok)
            begin
                cal_year   = c.set_year;
                cal_month  = c.set_month[3:0];
                cal_day    = c.set_day[4:0];
                cal_hour   = c.set_hour[4:0];
                cal_minute = c.set_minute[5:0];
                cal_second = c.set_second[5:0];
            end
            else
            begin
                r.status = 1'b1;
            end
        end
        // read and the spare code only report the time
        r.year   = cal_year;
        r.month  = cal_month;
        r.day    = cal_day;
        r.hour   = cal_hour;
        r.minute = cal_minute;
        r.second = cal_second;
        return r;
    endfunction

    function automatic string show_time(input rsp_t r);
        return $sformatf("st=%0d done=%0d %0d-%0d-%0d %0d:%0d:%0d", r.status,
                         r.second_done, r.year, r.month, r.day, r.hour, r.minute,
                         r.second);
    endfunction

    // only the first few failures are printed, the rest are counted
    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%t mismatch: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // result checker: every accepted result word against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_times.size() == 0)
            begin
                note_error($sformatf("unexpected word, got %s", show_time(rsp_word)));
            end
            else
            begin
                want = expected_times.pop_front();
                if (rsp_word.status !== want.status
                    || rsp_word.second_done !== want.second_done
                    || rsp_word.year !== want.year
                    || rsp_word.month !== want.month
                    || rsp_word.day !== want.day
                    || rsp_word.hour !== want.hour
                    || rsp_word.minute !== want.minute
                    || rsp_word.second !== want.second)
                    note_error($sformatf("expected %s, got %s", show_time(want),
                                         show_time(rsp_word)));
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stall, or a long hold-off when a test asks for one
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            rsp_stall <= 1'b1;
            hold_cycles--;
        end
        else
        begin
            rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // ------------------------------------------------------------------
    // watchdog: ends the run once nothing has moved for too long
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int idle_run;
        idle_run = 0;
        while (idle_run < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // sender: offers one command word, with random gaps, and waits for it to be taken
    // ------------------------------------------------------------------
    task automatic send_word(input cmd_t w);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < IDLE_PERCENT)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= w;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        // accepted at this edge
        expected_times.push_back(calendar_step(w));
    endtask

    // drop valid and wait until the block has nothing left in flight
    task automatic settle();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (expected_times.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one apb transfer: setup cycle, then access cycle until pready
    task automatic apb_access(input bit wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= RATE_ADDR;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_rate();
        logic [31:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd !== {12'd0, model_rate})
            note_error($sformatf("ticks_per_second read %0d, expected %0d", rd, model_rate));
    endtask

    // rate changes only while idle
    task automatic write_rate(input logic [19:0] rate);
        logic [31:0] rd;
        settle();
        apb_access(1'b1, {12'd0, rate}, rd);
        model_rate = rate;
        check_rate();
    endtask

    function automatic cmd_t make_word(input logic [1:0] act, input logic [13:0] y,
                                       input logic [6:0] mo, input logic [6:0] d,
                                       input logic [6:0] h, input logic [6:0] mi,
                                       input logic [6:0] s);
        cmd_t c;
        c.action     = act;
        c.set_year   = y;
        c.set_month  = mo;
        c.set_day    = d;
        c.set_hour   = h;
        c.set_minute = mi;
        c.set_second = s;
        return c;
    endfunction

    // mostly ticks and good sets near a rollover, the rest noise
    function automatic cmd_t random_cmd();
        cmd_t        c;
        logic [63:0] noise;
        int          pick;
        noise = {$urandom, $urandom};
        c = noise[50:0];
        pick = $urandom_range(99);
        if (pick < 62)
        begin
            c.action = ACT_TICK;
        end
        else if (pick < 80)
        begin
            c.action = ACT_SET;
            case ($urandom_range(2))
                0:       c.set_year = 14'($urandom_range(LOWEST_YEAR, HIGHEST_YEAR));
                1:       c.set_year = 14'(100 * $urandom_range(20, 30));
                default: c.set_year = 14'(4 * $urandom_range(500, 750));
            endcase
            c.set_month  = 7'($urandom_range(1, LAST_MONTH));
            c.set_day    = $urandom_range(1) ? 7'($urandom_range(27, LAST_DAY))
                                             : 7'($urandom_range(1, LAST_DAY));
            c.set_hour   = $urandom_range(1) ? 7'(HOURS_PER_DAY - 1)
                                             : 7'($urandom_range(0, HOURS_PER_DAY - 1));
            c.set_minute = $urandom_range(1) ? 7'(MINS_PER_HOUR - 1)
                                             : 7'($urandom_range(0, MINS_PER_HOUR - 1));
            c.set_second = $urandom_range(1) ? 7'(SECS_PER_MIN - 1)
                                             : 7'($urandom_range(0, SECS_PER_MIN - 1));
        end
        else if (pick < 88)
        begin
            // raw fields, nearly always rejected
            c.action = ACT_SET;
        end
        else if (pick < 95)
        begin
            c.action = ACT_READ;
        end
        else
        begin
            c.action = ACT_SPARE;
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // default rate, reads and ticks before any set; set fields ignored on a tick
    task automatic test_reset_state();
        check_rate();
        send_word(make_word(ACT_READ, '0, '0, '0, '0, '0, '0));
        send_word(make_word(ACT_SPARE, '1, '1, '1, '1, '1, '1));
        send_word(make_word(ACT_TICK, '1, '1, '1, '1, '1, '1));
        send_word(make_word(ACT_TICK, '0, '0, '0, '0, '0, '0));
    endtask

    // each field just outside its range is rejected, both ends of the range load
    task automatic test_set_checks();
        send_word(make_word(ACT_SET, 14'd1999, 7'd6, 7'd15, 7'd12, 7'd30, 7'd30));
        send_word(make_word(ACT_SET, 14'd3001, 7'd6, 7'd15, 7'd12, 7'd30, 7'd30));
        send_word(make_word(ACT_SET, 14'd2500, 7'd0, 7'd15, 7'd12, 7'd30, 7'd30));
        send_word(make_word(ACT_SET, 14'd2500, 7'd13, 7'd15, 7'd12, 7'd30, 7'd30));
        send_word(make_word(ACT_SET, 14'd2500, 7'd6, 7'd0, 7'd12, 7'd30, 7'd30));
        send_word(make_word(ACT_SET, 14'd2500, 7'd6, 7'd32, 7'd12, 7'd30, 7'd30));
        send_word(make_word(ACT_SET, 14'd2500, 7'd6, 7'd15, 7'd24, 7'd30, 7'd30));
        send_word(make_word(ACT_SET, 14'd2500, 7'd6, 7'd15, 7'd12, 7'd60, 7'd30));
        send_word(make_word(ACT_SET, 14'd2500, 7'd6, 7'd15, 7'd12, 7'd30, 7'd60));
        send_word(make_word(ACT_SET, '1, '1, '1, '1, '1, '1));
        send_word(make_word(ACT_SET, 14'd2000, 7'd1, 7'd1, 7'd0, 7'd0, 7'd0));
        send_word(make_word(ACT_SET, 14'd3000, 7'd12, 7'd31, 7'd23, 7'd59, 7'd59));
    endtask

    // one tick per second: year end, century non-leap, 400-year leap, day past month end
    task automatic test_rollovers();
        write_rate(20'd1);
        send_word(make_word(ACT_SET, 14'd3000, 7'd12, 7'd31, 7'd23, 7'd59, 7'd59));
        send_word(make_word(ACT_TICK, '0, '0, '0, '0, '0, '0));
        send_word(make_word(ACT_SET, 14'd2100, 7'd2, 7'd28, 7'd23, 7'd59, 7'd59));
        send_word(make_word(ACT_TICK, '0, '0, '0, '0, '0, '0));
        send_word(make_word(ACT_SET, 14'd2000, 7'd2, 7'd28, 7'd23, 7'd59, 7'd59));
        send_word(make_word(ACT_TICK, '0, '0, '0, '0, '0, '0));
        send_word(make_word(ACT_SET, 14'd2023, 7'd4, 7'd31, 7'd23, 7'd59, 7'd59));
        send_word(make_word(ACT_TICK, '0, '0, '0, '0, '0, '0));
    endtask

    // zero rate, then a rate lowered below the running divider
    task automatic test_rate_changes();
        int i;
        write_rate(20'd0);
        send_word(make_word(ACT_TICK, '0, '0, '0, '0, '0, '0));
        write_rate(20'd5);
        for (i = 0; i < 3; i++)
            send_word(make_word(ACT_TICK, '0, '0, '0, '0, '0, '0));
        write_rate(20'd2);
        for (i = 0; i < 3; i++)
            send_word(make_word(ACT_TICK, '0, '0, '0, '0, '0, '0));
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        int i;
        write_rate(20'd1);
        hold_cycles = HOLD_CYCLES;
        for (i = 0; i < 100; i++)
            send_word(random_cmd());
    endtask

    task automatic test_random_mix(input int count, input logic [19:0] rate,
                                   input bit no_idle);
        int i;
        write_rate(rate);
        quiet = no_idle;
        for (i = 0; i < count; i++)
            send_word(random_cmd());
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        // reset held low at start, then released on a falling edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_set_checks();
        test_rollovers();
        test_rate_changes();
        test_backpressure();

        // random traffic over several rates; the first run, at rate 1, has no idling at all
        test_random_mix(350, 20'd1, 1'b1);
        test_random_mix(450, 20'd2, 1'b0);
        test_random_mix(150, 20'd1000000, 1'b0);
        // divider left far above this rate by the phase before
        test_random_mix(350, 20'd3, 1'b0);
        test_random_mix(200, 20'hFFFFF, 1'b0);
        test_random_mix(300, 20'd0, 1'b0);

        settle();
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
